// File: design/lr_pkg.sv
// Shared constants and types for the line rasteriser.
// No dependencies; every other design file imports this package.
package lr_pkg;

    // Field width on the stream ports
    localparam int C_COORD_W     = 6;
    // Default for the usable coordinate width (2 to C_COORD_W)
    localparam int C_COORD_BITS  = 6;
    // Default depth of the segment queue between front and back
    localparam int C_QUEUE_DEPTH = 2;

    // Four coordinates in, two coordinates out, padded to whole bytes
    localparam int C_S_TDATA_W   = ((4 * C_COORD_W + 7) / 8) * 8;
    localparam int C_M_TDATA_W   = ((2 * C_COORD_W + 7) / 8) * 8;

    typedef logic [C_COORD_W-1:0] t_coord;

endpackage

// File: design/line_rasterizer_top.sv
// Top level of the line rasteriser: front classifier, segment queue and
// pixel-walking back end. Depends on lr_pkg, lr_front, lr_queue, lr_back.
//
//  Channel  | Ports               | tdata / tuser / tlast contents
//  ---------+---------------------+-------------------------------------------
//  segment  | i_s_* in, o_s_tready| tdata: start_x, start_y, end_x, end_y
//  pixel    | o_m_* out, i_m_tready| tdata: pixel_x, pixel_y; tlast: last_pixel
//
// Pixels: a segment of major length len yields len+1 pixels, one per cycle
// unless i_m_tready stalls the output register; the walker loads a segment
// from the queue only when idle, ahead of its first pixel.
// Reset: synchronous, active low; empties the queue and the output register.
// Stalls: the queue lets new segments in while the back end walks, and the
// output register holds a pixel while i_m_tready is low.
module line_rasterizer_top #(
    parameter int COORD_BITS  = lr_pkg::C_COORD_BITS,
    parameter int QUEUE_DEPTH = lr_pkg::C_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Segment stream in
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [5:0] start_x, [11:6] start_y, [17:12] end_x, [23:18] end_y
    input  logic [lr_pkg::C_S_TDATA_W-1:0] i_s_tdata,
    // Pixel stream out
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [5:0] pixel_x, [11:6] pixel_y, [15:12] zero
    output logic [lr_pkg::C_M_TDATA_W-1:0] o_m_tdata,
    // last_pixel
    output logic                           o_m_tlast
);
    import lr_pkg::*;

    localparam int SEG_W = 4 * COORD_BITS + 2;

    logic [SEG_W-1:0] front_seg;
    logic [SEG_W-1:0] queue_seg;
    logic             queue_valid;
    logic             back_ready;

    // Classify the incoming segment combinationally
    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_tdata (i_s_tdata),
        .o_seg   (front_seg)
    );

    // Hold classified segments until the walker is free
    lr_queue #(
        .DATA_W (SEG_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_s_tvalid),
        .o_push_ready (o_s_tready),
        .i_push_data  (front_seg),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (queue_seg)
    );

    // Walk each segment and emit one pixel per transaction
    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (queue_valid),
        .o_seg_ready (back_ready),
        .i_seg       (queue_seg),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// File: design/lr_front.sv
// Front end of the line rasteriser: classifies one segment (major axis,
// endpoint order, length, minor delta) into a packed descriptor.
// Depends on lr_pkg.
module lr_front #(
    parameter int COORD_BITS = lr_pkg::C_COORD_BITS,
    localparam int SEG_W     = 4 * COORD_BITS + 2
) (
    input  logic [lr_pkg::C_S_TDATA_W-1:0] i_tdata,
    output logic [SEG_W-1:0]               o_seg
);
    import lr_pkg::*;

    localparam int W = COORD_BITS;

    logic [W-1:0]        x0, y0, x1, y1;
    logic [W-1:0]        adx, ady;
    logic                along_x, swap;
    logic [W-1:0]        maj0, min0, min1, len;
    logic signed [W:0]   d;

    always_comb begin
        x0 = i_tdata[0*C_COORD_W +: W];
        y0 = i_tdata[1*C_COORD_W +: W];
        x1 = i_tdata[2*C_COORD_W +: W];
        y1 = i_tdata[3*C_COORD_W +: W];

        adx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        ady = (y1 > y0) ? (y1 - y0) : (y0 - y1);

        // Step along x only when x changes strictly more
        along_x = (ady < adx);
        swap    = along_x ? (x0 > x1) : (y0 > y1);

        if (along_x) begin
            maj0 = swap ? x1 : x0;
            min0 = swap ? y1 : y0;
            min1 = swap ? y0 : y1;
            len  = adx;
        end else begin
            maj0 = swap ? y1 : y0;
            min0 = swap ? x1 : x0;
            min1 = swap ? x0 : x1;
            len  = ady;
        end

        d = $signed({1'b0, min1}) - $signed({1'b0, min0});

        o_seg = {along_x, d, len, min0, maj0};
    end

endmodule

// File: design/lr_queue.sv
// Short segment queue between the front and back ends of the rasteriser.
// Register-based ring buffer; depends on lr_pkg for its default depth.
module lr_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lr_pkg::C_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);
    import lr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count missed a push");
`endif

endmodule

// File: design/lr_back.sv
// Back end of the line rasteriser: walks one segment a pixel per cycle unless
// the output stalls, tracking the rounded minor coordinate with a remainder
// accumulator. Depends on lr_pkg.
module lr_back #(
    parameter int COORD_BITS = lr_pkg::C_COORD_BITS,
    localparam int SEG_W     = 4 * COORD_BITS + 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_seg_valid,
    output logic                           o_seg_ready,
    input  logic [SEG_W-1:0]               i_seg,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lr_pkg::C_M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);
    import lr_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int ACC_W = W + 3;

    // Segment fields
    logic                    s_along;
    logic signed [W:0]       s_d;
    logic [W-1:0]            s_len, s_min0, s_maj0;

    // Walk state
    logic                    r_busy, n_busy;
    logic                    r_along;
    logic signed [W:0]       r_d;
    logic [W-1:0]            r_len;
    logic [W-1:0]            r_maj, n_maj;
    logic [W-1:0]            r_min, n_min;
    logic [W-1:0]            r_cnt, n_cnt;
    logic signed [ACC_W-1:0] r_rem, n_rem;

    // Output register
    logic                    r_ovalid, n_ovalid;
    t_coord                  r_px, r_py;
    logic                    r_last;

    logic                    load, emit;
    logic signed [ACC_W-1:0] step, twolen, sum;

    assign {s_along, s_d, s_len, s_min0, s_maj0} = i_seg;

    assign o_seg_ready = !r_busy;
    assign load        = i_seg_valid && !r_busy;
    assign emit        = r_busy && (!r_ovalid || i_m_tready);

    assign step   = ACC_W'(r_d) <<< 1;
    assign twolen = $signed(ACC_W'({r_len, 1'b0}));
    assign sum    = r_rem + step;

    always_comb begin
        n_busy   = r_busy;
        n_maj    = r_maj;
        n_min    = r_min;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_ovalid = r_ovalid;
        if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
        if (load) begin
            n_busy = 1'b1;
            n_maj  = s_maj0;
            n_min  = s_min0;
            n_cnt  = s_len;
            n_rem  = $signed(ACC_W'(s_len));
        end else if (emit) begin
            n_ovalid = 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                n_maj = r_maj + 1'b1;
                // Keep the remainder in [0, 2*len): one correction suffices
                if (sum >= twolen) begin
                    n_rem = sum - twolen;
                    n_min = r_min + 1'b1;
                end else if (sum < 0) begin
                    n_rem = sum + twolen;
                    n_min = r_min - 1'b1;
                end else begin
                    n_rem = sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_maj <= n_maj;
        r_min <= n_min;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        if (load) begin
            r_along <= s_along;
            r_d     <= s_d;
            r_len   <= s_len;
        end
        if (emit) begin
            r_px   <= r_along ? C_COORD_W'(r_maj) : C_COORD_W'(r_min);
            r_py   <= r_along ? C_COORD_W'(r_min) : C_COORD_W'(r_maj);
            r_last <= (r_cnt == '0);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = C_M_TDATA_W'({r_py, r_px});
    assign o_m_tlast  = r_last;

`ifndef NO_ASSERTIONS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_len != '0) |-> (r_rem >= 0 && r_rem < twolen))
        else $error("minor remainder out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_cnt == '0) |=> (!r_busy && r_ovalid && r_last))
        else $error("final pixel did not close the segment");
`endif

endmodule

// File: tb/lr_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for the line rasteriser: watches the segment and pixel streams,
// predicts the pixels of each accepted segment and compares them in order.
// Depends on lr_pkg; instantiated beside the block by tb_line_rasterizer_top.
module lr_pixel_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Segment stream, observed only
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [5:0] start_x, [11:6] start_y, [17:12] end_x, [23:18] end_y
    input  logic [lr_pkg::C_S_TDATA_W-1:0] i_s_tdata,
    // Pixel stream, observed only
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [5:0] pixel_x, [11:6] pixel_y, [15:12] zero
    input  logic [lr_pkg::C_M_TDATA_W-1:0] i_m_tdata,
    // last_pixel
    input  logic                           i_m_tlast,
    output int                             o_mismatches,
    output int                             o_pending
);
    import lr_pkg::*;

    localparam int C_REPORT_MAX = 10;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;

    // floor((2*t*d + den) / (2*den)), den > 0: exact slope rounded half up
    function automatic int round_half_up(int t, int d, int den);
        int num;
        int den2;
        num  = 2 * t * d + den;
        den2 = 2 * den;
        if (num >= 0)
            return num / den2;
        return -((-num + den2 - 1) / den2);
    endfunction

    // Walk the major axis from the lower end and queue every covering pixel
    function automatic void walk_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int x0, y0, x1, y1, adx, ady, len, px, py;
        bit along_x;
        x0 = sx;
        y0 = sy;
        x1 = ex;
        y1 = ey;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        along_x = ady < adx;
        if (along_x ? (x0 > x1) : (y0 > y1)) begin
            px = x0; x0 = x1; x1 = px;
            py = y0; y0 = y1; y1 = py;
        end
        len = along_x ? x1 - x0 : y1 - y0;
        for (int t = 0; t <= len; t++) begin
            if (len == 0) begin
                px = x0;
                py = y0;
            end else if (along_x) begin
                px = x0 + t;
                py = y0 + round_half_up(t, y1 - y0, len);
            end else begin
                py = y0 + t;
                px = x0 + round_half_up(t, x1 - x0, len);
            end
            expected_pixels.push_back('{x: t_coord'(px), y: t_coord'(py), last: (t == len)});
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (!i_rst_n) begin
            expected_pixels.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= C_REPORT_MAX)
                        $display("%0t: unexpected pixel tdata=%h last=%b",
                                 $time, i_m_tdata, i_m_tlast);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_m_tdata !== C_M_TDATA_W'({want.y, want.x}) ||
                        i_m_tlast !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= C_REPORT_MAX)
                            $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%b,",
                                     $time, want.x, want.y, want.last,
                                     " got tdata=%h (x=%0d y=%0d) last=%b",
                                     i_m_tdata, i_m_tdata[0 +: C_COORD_W],
                                     i_m_tdata[C_COORD_W +: C_COORD_W], i_m_tlast);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                walk_segment(i_s_tdata[0 +: C_COORD_W],
                             i_s_tdata[C_COORD_W +: C_COORD_W],
                             i_s_tdata[2*C_COORD_W +: C_COORD_W],
                             i_s_tdata[3*C_COORD_W +: C_COORD_W]);
        end
        o_pending    <= expected_pixels.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: tb/tb_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Testbench top for the line rasteriser: clock, reset, segment stimulus and
// pixel back-pressure, with lr_pixel_checker doing prediction and comparison.
// Depends on lr_pkg, line_rasterizer_top and lr_pixel_checker.
module tb_line_rasterizer_top;
    import lr_pkg::*;

    localparam int C_HALF_PERIOD     = 4;
    localparam int C_RESET_CYCLES    = 9;
    localparam int C_RANDOM_SEGMENTS = 450;
    // Long enough for the queue and the walker to fill and stall the input
    localparam int C_HOLD_OFF_CYCLES = 300;
    // Enough for one full line through the back end, plus margin
    localparam int C_DRAIN_CYCLES    = 80;
    // Worst quiet stretch: the hold-off plus the longest gaps on both sides
    localparam int C_WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        t_coord ey;
        t_coord ex;
        t_coord sy;
        t_coord sx;
    } t_segment;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [C_S_TDATA_W-1:0] i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [C_M_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    int mismatches;
    int pending_pixels;
    int quiet_cycles    = 0;
    // Hold-off requests from the stimulus, served by the pixel sink
    int hold_off_asked  = 0;
    int hold_off_served = 0;
    // While set, the sender offers segments back to back
    bit burst_mode      = 0;

    line_rasterizer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    lr_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending_pixels)
    );

    initial begin
        i_clk = 1'b0;
        forever #C_HALF_PERIOD i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    // Pick two coordinates len apart, in random order
    function automatic void span(int len, output int a, output int b);
        int tmp;
        a = $urandom_range(0, 63 - len);
        b = a + len;
        if ($urandom_range(0, 1)) begin
            tmp = a; a = b; b = tmp;
        end
    endfunction

    // Draw a segment from a mix of shapes: arbitrary, short, axis-aligned,
    // diagonal, one off diagonal (either side of the x/y decision) and a point
    function automatic t_segment random_segment();
        int a, b, c, d, len, tmp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                a = $urandom_range(0, 63);
                b = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
                d = $urandom_range(0, 63);
            end
            4, 5: begin
                span($urandom_range(0, 5), a, b);
                span($urandom_range(0, 5), c, d);
            end
            6: begin
                span($urandom_range(0, 63), a, b);
                c = $urandom_range(0, 63);
                d = c;
            end
            7: begin
                len = $urandom_range(0, 63);
                span(len, a, b);
                span(len, c, d);
            end
            8: begin
                len = $urandom_range(1, 62);
                span(len, a, b);
                span($urandom_range(0, 1) ? len + 1 : len - 1, c, d);
            end
            default: begin
                a = $urandom_range(0, 63);
                b = a;
                c = $urandom_range(0, 63);
                d = c;
            end
        endcase
        // Swap the axes half the time so both orientations get every shape
        if ($urandom_range(0, 1)) begin
            tmp = a; a = c; c = tmp;
            tmp = b; b = d; d = tmp;
        end
        return '{sx: t_coord'(a), sy: t_coord'(c), ex: t_coord'(b), ey: t_coord'(d)};
    endfunction

    // Offer one segment and hold it until the block takes it, then idle for a
    // random gap unless bursting. tvalid stays high across a zero gap, so the
    // next offer only updates tdata in that step.
    task automatic offer_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= C_S_TDATA_W'({ey, ex, sy, sx});
        do @(posedge i_clk); while (!o_s_tready);
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop tvalid and wait until every predicted pixel has come out. The
    // first edge lets the pending count take in the last accepted segment.
    task automatic drain_pixels();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels != 0);
    endtask

    // Segment stimulus: directed corners and special cases, then random mix
    initial begin : segment_source
        t_segment seg;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (C_RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Coincident endpoints at both corners of the field
        offer_segment(0, 0, 0, 0);
        offer_segment(63, 63, 63, 63);
        // Horizontal and vertical, full length, both directions
        offer_segment(0, 0, 63, 0);
        offer_segment(63, 63, 0, 63);
        offer_segment(0, 0, 0, 63);
        offer_segment(63, 63, 63, 0);
        // Equal change in size steps along y: both diagonals, both directions
        offer_segment(0, 0, 63, 63);
        offer_segment(63, 63, 0, 0);
        offer_segment(63, 0, 0, 63);
        offer_segment(0, 63, 63, 0);
        // Just either side of the diagonal
        offer_segment(0, 0, 63, 62);
        offer_segment(0, 0, 62, 63);
        offer_segment(63, 1, 0, 63);
        offer_segment(1, 63, 63, 0);
        // Exact halves: rounding up on rising and on falling slopes
        offer_segment(10, 20, 12, 21);
        offer_segment(0, 1, 2, 0);
        offer_segment(21, 10, 20, 12);
        offer_segment(40, 41, 38, 40);
        // Two-pixel lines and a couple of odd slopes
        offer_segment(5, 5, 6, 5);
        offer_segment(5, 5, 5, 4);
        offer_segment(32, 17, 40, 50);
        offer_segment(1, 2, 3, 60);
        offer_segment(60, 3, 2, 29);
        drain_pixels();

        for (int i = 0; i < C_RANDOM_SEGMENTS; i++) begin
            if (i % 60 == 0) begin
                burst_mode = ($urandom_range(0, 3) == 0);
                // Stall the sink for a long stretch while segments keep coming
                if (i == 60 || i == 240) begin
                    hold_off_asked++;
                    burst_mode = 1;
                end
            end
            // Pause the sender until the block has emptied completely
            if (i == 150 || i == 330)
                drain_pixels();
            seg = random_segment();
            offer_segment(seg.sx, seg.sy, seg.ex, seg.ey);
        end

        drain_pixels();
        // Let any stray pixel surface before giving the verdict
        repeat (C_DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Pixel sink: ready runs of random length separated by random gaps, with
    // an occasional long stretch of no back-pressure, and a long hold-off
    // whenever the stimulus asks for one
    initial begin : pixel_sink
        int run_len;
        int gap;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_served != hold_off_asked) begin
                hold_off_served++;
                i_m_tready <= 1'b0;
                repeat (C_HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            i_m_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Watchdog: count cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= C_WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
